// ===== rtl/assert_macros.svh =====
// Shared assertion macros for the allocator checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BFPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define BFPA_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== rtl/bfpa_pkg.sv =====
package bfpa_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_HELD    = 2'd2;
  localparam logic [1:0] ST_NOOWNER = 2'd3;

  localparam logic       KIND_REQUEST = 1'b0;
  localparam logic       KIND_RELEASE = 1'b1;

  localparam logic [7:0] RESET_UNITS = 8'd100;

endpackage

// ===== rtl/bfpa_ram.sv =====
module bfpa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/best_fit_partition_allocator_core.sv =====
// Best-fit partition allocator. Pulse start with an operation while busy is
// low; busy then stays high until the result has been shown. Every operation
// gives exactly one result, on out_status/out_block_address for one cycle
// with out_valid high; the receiver cannot stall it, so sample it then. The
// partition table lives in one single-port-write RAM of MAX_PARTS entries
// with a registered read; every operation sweeps that RAM one entry a
// cycle. A request makes one table sweep, decides, and does up to two
// writes before its result. A release that finds its owner makes an owner
// sweep and a neighbor sweep and does up to three writes; a release with
// no owner makes one sweep, decides and shows its result. After reset, and
// after every transfer on the cfg channel, the block rebuilds the table as
// one free partition of total_r units, with busy high. A cfg write clamps
// the value to 1..MEM_UNITS and drops all blocks; write cfg only while
// busy is low and no result is pending.
module best_fit_partition_allocator_core
  import bfpa_pkg::*;
#(
  parameter int MEM_UNITS = 128,
  parameter int MAX_PARTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_kind,
  input  logic [7:0] in_owner_id,
  input  logic [7:0] in_request_size,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [6:0] out_block_address,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int AW   = $clog2(MEM_UNITS);
  localparam int SW0  = $clog2(MEM_UNITS + 1);
  localparam int SW   = (SW0 > 8) ? SW0 : 8;
  localparam int IW   = $clog2(MAX_PARTS);
  localparam int CNW  = $clog2(MAX_PARTS + 1);

  typedef struct packed {
    logic          vld;
    logic [AW-1:0] start;
    logic [SW-1:0] size;
    logic          bsy;
    logic [7:0]    owner;
  } entry_t;

  localparam int EW = $bits(entry_t);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_SCAN1 = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_SCAN2 = 3'd4;
  localparam logic [2:0] S_WA    = 3'd5;
  localparam logic [2:0] S_WB    = 3'd6;
  localparam logic [2:0] S_WC    = 3'd7;

  localparam logic [CNW-1:0] CNT_LAST = CNW'(MAX_PARTS);
  localparam logic [CNW-1:0] CLR_LAST = CNW'(MAX_PARTS - 1);
  localparam logic [SW-1:0]  UNITS_MAX = SW'(MEM_UNITS);

  logic [2:0]     state_r, state_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]  total_r, total_nxt;
  logic           kind_r, kind_nxt;
  logic [7:0]     own_r, own_nxt;
  logic [SW-1:0]  req_r, req_nxt;

  // Owner entry of the current operation.
  logic           fnd_r, fnd_nxt;
  logic [IW-1:0]  blk_r, blk_nxt;
  logic [AW-1:0]  bstart_r, bstart_nxt;
  logic [SW-1:0]  bsize_r, bsize_nxt;

  // Best-fit candidate and first free slot.
  logic           best_r, best_nxt;
  logic [IW-1:0]  best_idx_r, best_idx_nxt;
  logic [AW-1:0]  best_start_r, best_start_nxt;
  logic [SW-1:0]  best_size_r, best_size_nxt;
  logic           slot_r, slot_nxt;
  logic [IW-1:0]  slot_idx_r, slot_idx_nxt;
  logic           split_r, split_nxt;

  // Free neighbors of a released block.
  logic           lo_r, lo_nxt;
  logic [IW-1:0]  lo_idx_r, lo_idx_nxt;
  logic [AW-1:0]  lo_start_r, lo_start_nxt;
  logic [SW-1:0]  lo_size_r, lo_size_nxt;
  logic           hi_r, hi_nxt;
  logic [IW-1:0]  hi_idx_r, hi_idx_nxt;
  logic [SW-1:0]  hi_size_r, hi_size_nxt;

  logic [1:0]     res_st_r, res_st_nxt;
  logic [AW-1:0]  res_addr_r, res_addr_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_st_r, out_st_nxt;
  logic [AW-1:0]  out_addr_r, out_addr_nxt;

  logic           ram_we;
  logic [IW-1:0]  ram_waddr, ram_raddr;
  entry_t         ram_wdata, rd;
  logic [EW-1:0]  ram_rdata;

  logic           accept;
  logic [CNW-1:0] cnt_m1;
  logic [IW-1:0]  rd_idx;
  logic [SW-1:0]  rd_end, bend, merged, cfg_ext, cfg_clamped;
  logic           better;

  bfpa_ram #(.W(EW), .D(MAX_PARTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd        = entry_t'(ram_rdata);
  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign cnt_m1    = cnt_r - CNW'(1);
  assign rd_idx    = cnt_m1[IW-1:0];
  assign ram_raddr = cnt_r[IW-1:0];
  assign rd_end    = SW'(rd.start) + rd.size;
  assign bend      = SW'(bstart_r) + bsize_r;
  assign merged    = bsize_r + (hi_r ? hi_size_r : SW'(0));
  assign better    = !best_r || (rd.size < best_size_r) ||
                     ((rd.size == best_size_r) && (rd.start < best_start_r));

  // Clamp the written pool size to 1..MEM_UNITS.
  always_comb begin
    cfg_ext = SW'(cfg_data);
    if (cfg_ext == SW'(0)) begin
      cfg_clamped = SW'(1);
    end else if (cfg_ext > UNITS_MAX) begin
      cfg_clamped = UNITS_MAX;
    end else begin
      cfg_clamped = cfg_ext;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    total_nxt      = total_r;
    kind_nxt       = kind_r;
    own_nxt        = own_r;
    req_nxt        = req_r;
    fnd_nxt        = fnd_r;
    blk_nxt        = blk_r;
    bstart_nxt     = bstart_r;
    bsize_nxt      = bsize_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    best_start_nxt = best_start_r;
    best_size_nxt  = best_size_r;
    slot_nxt       = slot_r;
    slot_idx_nxt   = slot_idx_r;
    split_nxt      = split_r;
    lo_nxt         = lo_r;
    lo_idx_nxt     = lo_idx_r;
    lo_start_nxt   = lo_start_r;
    lo_size_nxt    = lo_size_r;
    hi_nxt         = hi_r;
    hi_idx_nxt     = hi_idx_r;
    hi_size_nxt    = hi_size_r;
    res_st_nxt     = res_st_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = 1'b0;
    out_st_nxt     = out_st_r;
    out_addr_nxt   = out_addr_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[IW-1:0];
    ram_wdata      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // Latch the operation and clear all search results.
          kind_nxt  = in_kind;
          own_nxt   = in_owner_id;
          req_nxt   = SW'(in_request_size);
          fnd_nxt   = 1'b0;
          best_nxt  = 1'b0;
          slot_nxt  = 1'b0;
          lo_nxt    = 1'b0;
          hi_nxt    = 1'b0;
          cnt_nxt   = '0;
          state_nxt = S_SCAN1;
        end
      end
      S_CLEAR: begin
        // Rebuild the table: entry zero holds the whole pool, the rest drop.
        ram_we = 1'b1;
        if (cnt_r == '0) begin
          ram_wdata.vld  = 1'b1;
          ram_wdata.size = total_r;
        end
        cnt_nxt = cnt_r + CNW'(1);
        if (cnt_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN1: begin
        // Data of entry cnt-1 is on the read port; find owner, best fit, slot.
        if (cnt_r != '0) begin
          if (!fnd_r && rd.vld && rd.bsy && (rd.owner == own_r)) begin
            fnd_nxt    = 1'b1;
            blk_nxt    = rd_idx;
            bstart_nxt = rd.start;
            bsize_nxt  = rd.size;
          end
          if (rd.vld && !rd.bsy && (rd.size >= req_r) && better) begin
            best_nxt       = 1'b1;
            best_idx_nxt   = rd_idx;
            best_start_nxt = rd.start;
            best_size_nxt  = rd.size;
          end
          if (!slot_r && !rd.vld) begin
            slot_nxt     = 1'b1;
            slot_idx_nxt = rd_idx;
          end
        end
        cnt_nxt = cnt_r + CNW'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        res_addr_nxt = '0;
        state_nxt    = S_WA;
        cnt_nxt      = '0;
        if (kind_r == KIND_REQUEST) begin
          split_nxt = (best_size_r != req_r);
          if (fnd_r) begin
            res_st_nxt = ST_HELD;
            state_nxt  = S_WC;
          end else if ((req_r == '0) || !best_r ||
                       ((best_size_r != req_r) && !slot_r)) begin
            res_st_nxt = ST_NOFIT;
            state_nxt  = S_WC;
          end else begin
            res_st_nxt   = ST_OK;
            res_addr_nxt = AW'(best_start_r + AW'(best_size_r - req_r));
          end
        end else begin
          if (!fnd_r) begin
            res_st_nxt = ST_NOOWNER;
            state_nxt  = S_WC;
          end else begin
            res_st_nxt   = ST_OK;
            res_addr_nxt = bstart_r;
            state_nxt    = S_SCAN2;
          end
        end
      end
      S_SCAN2: begin
        // Look for free neighbors ending at bstart or starting at bend.
        if ((cnt_r != '0) && (rd_idx != blk_r) && rd.vld && !rd.bsy) begin
          if (!lo_r && (rd_end == SW'(bstart_r))) begin
            lo_nxt       = 1'b1;
            lo_idx_nxt   = rd_idx;
            lo_start_nxt = rd.start;
            lo_size_nxt  = rd.size;
          end else if (!hi_r && (SW'(rd.start) == bend)) begin
            hi_nxt      = 1'b1;
            hi_idx_nxt  = rd_idx;
            hi_size_nxt = rd.size;
          end
        end
        cnt_nxt = cnt_r + CNW'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_WA;
        end
      end
      S_WA: begin
        state_nxt = S_WB;
        if (kind_r == KIND_REQUEST) begin
          // Mark an exact fit busy, or shrink the partition being split.
          ram_we          = 1'b1;
          ram_waddr       = best_idx_r;
          ram_wdata.vld   = 1'b1;
          ram_wdata.start = best_start_r;
          if (split_r) begin
            ram_wdata.size = best_size_r - req_r;
          end else begin
            ram_wdata.size  = best_size_r;
            ram_wdata.bsy   = 1'b1;
            ram_wdata.owner = own_r;
          end
        end else begin
          // Drop the upper neighbor; its units fold into the freed block.
          ram_we    = hi_r;
          ram_waddr = hi_idx_r;
        end
      end
      S_WB: begin
        state_nxt = S_WC;
        if (kind_r == KIND_REQUEST) begin
          ram_we          = split_r;
          ram_waddr       = slot_idx_r;
          ram_wdata.vld   = 1'b1;
          ram_wdata.start = res_addr_r;
          ram_wdata.size  = req_r;
          ram_wdata.bsy   = 1'b1;
          ram_wdata.owner = own_r;
        end else begin
          ram_we        = 1'b1;
          ram_wdata.vld = 1'b1;
          if (lo_r) begin
            ram_waddr       = lo_idx_r;
            ram_wdata.start = lo_start_r;
            ram_wdata.size  = lo_size_r + merged;
          end else begin
            ram_waddr       = blk_r;
            ram_wdata.start = bstart_r;
            ram_wdata.size  = merged;
          end
        end
      end
      S_WC: begin
        // Drop the released entry when it merged down; then show the result.
        ram_we        = (kind_r == KIND_RELEASE) && fnd_r && lo_r;
        ram_waddr     = blk_r;
        out_valid_nxt = 1'b1;
        out_st_nxt    = res_st_r;
        out_addr_nxt  = res_addr_r;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A cfg transfer sets the pool size and restarts the table rebuild.
    if (cfg_valid && cfg_ready) begin
      total_nxt = cfg_clamped;
      cnt_nxt   = '0;
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      total_r     <= SW'(RESET_UNITS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    own_r        <= own_nxt;
    req_r        <= req_nxt;
    fnd_r        <= fnd_nxt;
    blk_r        <= blk_nxt;
    bstart_r     <= bstart_nxt;
    bsize_r      <= bsize_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    best_start_r <= best_start_nxt;
    best_size_r  <= best_size_nxt;
    slot_r       <= slot_nxt;
    slot_idx_r   <= slot_idx_nxt;
    split_r      <= split_nxt;
    lo_r         <= lo_nxt;
    lo_idx_r     <= lo_idx_nxt;
    lo_start_r   <= lo_start_nxt;
    lo_size_r    <= lo_size_nxt;
    hi_r         <= hi_nxt;
    hi_idx_r     <= hi_idx_nxt;
    hi_size_r    <= hi_size_nxt;
    res_st_r     <= res_st_nxt;
    res_addr_r   <= res_addr_nxt;
    out_st_r     <= out_st_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_st_r;
  assign out_block_address = 7'(out_addr_r);

endmodule

// ===== rtl/bfpa_checker.sv =====
`include "assert_macros.svh"

module bfpa_checker
  import bfpa_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [6:0] out_block_address
);

  `BFPA_ASSERT(a_fail_addr_zero, clk, rst_n, !(out_valid && (out_status != ST_OK)) || (out_block_address == 7'd0), "failed result carries a nonzero address")
  `BFPA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted operation did not raise busy")
  `BFPA_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe lasted more than one cycle")
  `BFPA_ASSERT(a_result_from_work, clk, rst_n, !out_valid || $past(busy), "result shown without a preceding operation")

endmodule

bind best_fit_partition_allocator_core bfpa_checker u_bfpa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_block_address (out_block_address)
);
